/* hw/rtl/tws_pkg.sv */
// Shared types and constants for the TFTP write sender control block.
// Used by tws_ctrl and tftp_write_sender_control; depends on nothing.
`default_nettype none

package tws_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

  localparam logic [7:0]  MAX_RETRIES_RST   = 8'd5;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  localparam logic [7:0] OP_ACK = 8'd4;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ACK0  = 4'b0010,
    PH_FETCH = 4'b0100,
    PH_WAIT  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_BLOCK  = 2'd1,
    ACT_PACKET = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_FETCH  = 3'd1,
    CMD_SEND   = 3'd2,
    CMD_RESEND = 3'd3,
    CMD_DONE   = 3'd4,
    CMD_FAIL   = 3'd5
  } cmd_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] block_counter;
    logic [9:0]  sent_length;
    logic [7:0]  attempts_used;
    logic [15:0] tick_count;
    logic        final_block;
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [9:0]  byte_count;
    logic [7:0]  rx_opcode;
    logic [15:0] rx_block;
    logic        source_match;
  } item_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] tx_block;
    logic [9:0]  payload_length;
  } result_t;

  typedef struct packed {
    logic [7:0]  max_retries;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/tws_ctrl.sv */
// Next-state and command logic for one event of the TFTP write sender.
// Purely combinational; uses types and codes from tws_pkg.
`default_nettype none

module tws_ctrl #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  tws_pkg::state_t  st,
  input  tws_pkg::item_t   item,
  input  tws_pkg::cfg_t    cfg,
  output tws_pkg::state_t  st_nxt,
  output tws_pkg::result_t res
);

  localparam logic [16:0] BLOCK_LEN = 17'(BLOCK_BYTES);

  logic [7:0]  ack0_limit;
  logic [7:0]  att_inc;
  logic [15:0] tick_inc;
  logic [15:0] tick_limit;
  logic        expired;
  logic        good;
  logic [16:0] byte_ext;
  logic [16:0] len;
  tws_pkg::cmd_t cmd;

  assign ack0_limit = (cfg.max_retries > 8'd2) ? (cfg.max_retries - 8'd2) : 8'd0;
  assign att_inc    = st.attempts_used + 8'd1;
  assign tick_inc   = st.tick_count + 16'd1;
  assign tick_limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
  assign expired    = (tick_inc >= tick_limit);
  assign good       = (item.rx_opcode == tws_pkg::OP_ACK) &&
                      (item.rx_block == st.block_counter);
  assign byte_ext   = {7'd0, item.byte_count};
  // saturate oversized blocks
  assign len        = (byte_ext > BLOCK_LEN) ? BLOCK_LEN : byte_ext;

  always_comb begin
    st_nxt = st;
    cmd    = tws_pkg::CMD_NONE;
    unique case (item.action)
      tws_pkg::ACT_START: begin
        st_nxt.block_counter = 16'd0;
        st_nxt.sent_length   = 10'd0;
        st_nxt.attempts_used = 8'd0;
        st_nxt.tick_count    = 16'd0;
        st_nxt.final_block   = 1'b0;
        if (ack0_limit == 8'd0) begin
          st_nxt.phase = tws_pkg::PH_FETCH;
          cmd          = tws_pkg::CMD_FETCH;
        end else begin
          st_nxt.phase = tws_pkg::PH_ACK0;
        end
      end
      tws_pkg::ACT_BLOCK: begin
        if (st.phase == tws_pkg::PH_FETCH) begin
          st_nxt.block_counter = st.block_counter + 16'd1;
          st_nxt.sent_length   = len[9:0];
          st_nxt.final_block   = (len != BLOCK_LEN);
          st_nxt.attempts_used = 8'd0;
          st_nxt.tick_count    = 16'd0;
          st_nxt.phase         = tws_pkg::PH_WAIT;
          cmd                  = tws_pkg::CMD_SEND;
        end
      end
      tws_pkg::ACT_PACKET: begin
        if ((st.phase == tws_pkg::PH_ACK0) || (st.phase == tws_pkg::PH_WAIT)) begin
          st_nxt.tick_count = 16'd0;
          if (!item.source_match) begin
            // foreign packet: only restart the timeout
          end else if (good) begin
            if ((st.phase == tws_pkg::PH_WAIT) && st.final_block) begin
              st_nxt.phase = tws_pkg::PH_IDLE;
              cmd          = tws_pkg::CMD_DONE;
            end else begin
              st_nxt.phase = tws_pkg::PH_FETCH;
              cmd          = tws_pkg::CMD_FETCH;
            end
          end else begin
            st_nxt.attempts_used = att_inc;
            if (st.phase == tws_pkg::PH_ACK0) begin
              if (att_inc >= ack0_limit) begin
                st_nxt.phase = tws_pkg::PH_FETCH;
                cmd          = tws_pkg::CMD_FETCH;
              end
            end else if (att_inc >= cfg.max_retries) begin
              st_nxt.phase = tws_pkg::PH_IDLE;
              cmd          = tws_pkg::CMD_FAIL;
            end else begin
              cmd = tws_pkg::CMD_RESEND;
            end
          end
        end
      end
      tws_pkg::ACT_TICK: begin
        if ((st.phase == tws_pkg::PH_ACK0) || (st.phase == tws_pkg::PH_WAIT)) begin
          st_nxt.tick_count = tick_inc;
          if (expired) begin
            st_nxt.tick_count    = 16'd0;
            st_nxt.attempts_used = att_inc;
            if (st.phase == tws_pkg::PH_ACK0) begin
              if (att_inc >= ack0_limit) begin
                st_nxt.phase = tws_pkg::PH_FETCH;
                cmd          = tws_pkg::CMD_FETCH;
              end
            end else if (att_inc >= cfg.max_retries) begin
              st_nxt.phase = tws_pkg::PH_IDLE;
              cmd          = tws_pkg::CMD_FAIL;
            end else begin
              cmd = tws_pkg::CMD_RESEND;
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    res.command = cmd;
    if ((cmd == tws_pkg::CMD_SEND) || (cmd == tws_pkg::CMD_RESEND)) begin
      res.tx_block       = st_nxt.block_counter;
      res.payload_length = st_nxt.sent_length;
    end else begin
      res.tx_block       = 16'd0;
      res.payload_length = 10'd0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tftp_write_sender_control.sv */
// Top level of the TFTP write sender control block: stream ports, config
// registers, transfer state and result register. Uses tws_pkg and tws_ctrl.
//
// Each accepted event (start, file block ready, packet received, time tick)
// yields exactly one command on the output stream, in the cycle after it is
// taken. A new event can be taken in every cycle: the transfer state is
// updated in a single pass and the command lands in an output register, so
// the input stalls only while that register holds a command the consumer has
// not taken. Configuration writes are always accepted and should be made
// while no event is in flight.
`default_nettype none

module tftp_write_sender_control #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // event stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: byte_count[9:0], rx_opcode[17:10], rx_block[33:18], source_match[34]
  input  wire logic [tws_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: action[1:0]
  input  wire logic [1:0]                        in_tuser,
  // command stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata: tx_block[15:0], payload_length[25:16]
  output logic [tws_pkg::OUT_DATA_W-1:0]         out_tdata,
  // tuser: command[2:0]
  output logic [2:0]                             out_tuser,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tws_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tws_pkg::cfg_t    cfg_r;
  tws_pkg::state_t  st_r;
  tws_pkg::state_t  st_nxt;
  tws_pkg::item_t   item;
  tws_pkg::result_t res;
  tws_pkg::result_t res_r;
  logic             out_valid_r;
  logic             in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign item.action       = tws_pkg::action_t'(in_tuser);
  assign item.byte_count   = in_tdata[9:0];
  assign item.rx_opcode    = in_tdata[17:10];
  assign item.rx_block     = in_tdata[33:18];
  assign item.source_match = in_tdata[34];

  tws_ctrl #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_ctrl (
    .st     (st_r),
    .item   (item),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_retries   <= tws_pkg::MAX_RETRIES_RST;
      cfg_r.timeout_ticks <= tws_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tws_pkg::CFG_MAX_RETRIES:   cfg_r.max_retries   <= cfg_data[7:0];
        tws_pkg::CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= tws_pkg::PH_IDLE;
      st_r.block_counter <= 16'd0;
      st_r.sent_length   <= 10'd0;
      st_r.attempts_used <= 8'd0;
      st_r.tick_count    <= 16'd0;
      st_r.final_block   <= 1'b0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // hold the command until the consumer takes the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.command;
  assign out_tdata  = {6'd0, res_r.payload_length, res_r.tx_block};

endmodule

`default_nettype wire

/* sim/tftp_write_sender_control_tb.sv */
`timescale 1ns / 1ps
// Testbench for tftp_write_sender_control: drives transfer events through the
// event stream and checks every command against a scoreboard that tracks the
// transfer. Depends on tws_pkg and the block's RTL.

module tftp_write_sender_control_tb;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam logic [7:0]  OP_DATA     = 8'd3;

  class transfer_scoreboard;
    logic [7:0]       max_retries;
    logic [15:0]      timeout_ticks;
    tws_pkg::phase_t  ph;
    logic [15:0]      block_num;
    logic [9:0]       sent_len;
    logic [7:0]       attempts;
    logic [15:0]      ticks;
    logic             last_block;
    tws_pkg::result_t pending_cmds[$];
    int               mismatches;
    int               events_seen;
    int               cmd_seen[8];

    function new();
      max_retries   = tws_pkg::MAX_RETRIES_RST;
      timeout_ticks = tws_pkg::TIMEOUT_TICKS_RST;
      ph            = tws_pkg::PH_IDLE;
      block_num     = '0;
      sent_len      = '0;
      attempts      = '0;
      ticks         = '0;
      last_block    = 1'b0;
      mismatches    = 0;
      events_seen   = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    function void set_register(logic [tws_pkg::CFG_IDX_W-1:0] idx,
                               logic [tws_pkg::CFG_DATA_W-1:0] value);
      if (idx == tws_pkg::CFG_MAX_RETRIES) max_retries = value[7:0];
      else timeout_ticks = value;
    endfunction

    function logic [7:0] ack0_limit();
      return (max_retries > 8'd2) ? max_retries - 8'd2 : 8'd0;
    endfunction

    function bit tick_expired();
      logic [15:0] lim;
      lim = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
      ticks = ticks + 16'd1;
      return ticks >= lim;
    endfunction

    function tws_pkg::cmd_t ack0_failure();
      attempts = attempts + 8'd1;
      ticks = '0;
      // out of ACK 0 attempts: move on to the first block anyway
      if (attempts >= ack0_limit()) begin
        ph = tws_pkg::PH_FETCH;
        return tws_pkg::CMD_FETCH;
      end
      return tws_pkg::CMD_NONE;
    endfunction

    function tws_pkg::cmd_t data_failure();
      attempts = attempts + 8'd1;
      ticks = '0;
      if (attempts >= max_retries) begin
        ph = tws_pkg::PH_IDLE;
        return tws_pkg::CMD_FAIL;
      end
      return tws_pkg::CMD_RESEND;
    endfunction

    function void note_event(tws_pkg::item_t it);
      tws_pkg::cmd_t    cmd;
      logic [9:0]       len;
      logic             good;
      tws_pkg::result_t exp;
      cmd = tws_pkg::CMD_NONE;
      events_seen++;
      case (it.action)
        tws_pkg::ACT_START: begin
          block_num  = '0;
          sent_len   = '0;
          attempts   = '0;
          ticks      = '0;
          last_block = 1'b0;
          if (ack0_limit() == 8'd0) begin
            ph  = tws_pkg::PH_FETCH;
            cmd = tws_pkg::CMD_FETCH;
          end else begin
            ph = tws_pkg::PH_ACK0;
          end
        end
        tws_pkg::ACT_BLOCK: begin
          if (ph == tws_pkg::PH_FETCH) begin
            len        = (it.byte_count > BLOCK_BYTES) ? 10'(BLOCK_BYTES) : it.byte_count;
            block_num  = block_num + 16'd1;
            sent_len   = len;
            last_block = (len != BLOCK_BYTES);
            attempts   = '0;
            ticks      = '0;
            ph         = tws_pkg::PH_WAIT;
            cmd        = tws_pkg::CMD_SEND;
          end
        end
        tws_pkg::ACT_PACKET: begin
          if (ph == tws_pkg::PH_ACK0 || ph == tws_pkg::PH_WAIT) begin
            if (!it.source_match) begin
              // foreign sender: drop it but restart the timeout
              ticks = '0;
            end else begin
              good = (it.rx_opcode == tws_pkg::OP_ACK) && (it.rx_block == block_num);
              if (ph == tws_pkg::PH_ACK0) begin
                if (good) begin
                  ph    = tws_pkg::PH_FETCH;
                  ticks = '0;
                  cmd   = tws_pkg::CMD_FETCH;
                end else begin
                  cmd = ack0_failure();
                end
              end else if (good) begin
                ticks = '0;
                if (last_block) begin
                  ph  = tws_pkg::PH_IDLE;
                  cmd = tws_pkg::CMD_DONE;
                end else begin
                  ph  = tws_pkg::PH_FETCH;
                  cmd = tws_pkg::CMD_FETCH;
                end
              end else begin
                cmd = data_failure();
              end
            end
          end
        end
        default: begin
          if (ph == tws_pkg::PH_ACK0) begin
            if (tick_expired()) cmd = ack0_failure();
          end else if (ph == tws_pkg::PH_WAIT) begin
            if (tick_expired()) cmd = data_failure();
          end
        end
      endcase
      exp.command        = cmd;
      exp.tx_block       = (cmd == tws_pkg::CMD_SEND || cmd == tws_pkg::CMD_RESEND) ?
                           block_num : '0;
      exp.payload_length = (cmd == tws_pkg::CMD_SEND || cmd == tws_pkg::CMD_RESEND) ?
                           sent_len : '0;
      pending_cmds.push_back(exp);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_command(tws_pkg::result_t got);
      tws_pkg::result_t exp;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("command %0d with nothing outstanding", got.command));
        return;
      end
      exp = pending_cmds.pop_front();
      cmd_seen[exp.command]++;
      if (got.command !== exp.command)
        report_mismatch($sformatf("command %0d, expected %0d", got.command, exp.command));
      if (got.tx_block !== exp.tx_block)
        report_mismatch($sformatf("tx_block %0d, expected %0d", got.tx_block, exp.tx_block));
      if (got.payload_length !== exp.payload_length)
        report_mismatch($sformatf("payload_length %0d, expected %0d",
                                  got.payload_length, exp.payload_length));
    endtask
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [tws_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]                     in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [tws_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [2:0]                     out_tuser;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [tws_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [tws_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  transfer_scoreboard sb;
  bit idling         = 1'b1;
  int stall_left     = 0;
  int quiet_cycles   = 0;
  int settings_used  = 0;

  tftp_write_sender_control #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Command sink: check each transaction, stall in random bursts.
  always @(posedge clk) begin : out_sink
    tws_pkg::result_t got;
    if (out_tvalid && out_tready) begin
      got.command        = tws_pkg::cmd_t'(out_tuser);
      got.tx_block       = out_tdata[15:0];
      got.payload_length = out_tdata[25:16];
      sb.check_command(got);
    end
    if (idling && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 9);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tws_pkg::item_t mk_event(tws_pkg::action_t act, logic [9:0] bytes,
                                              logic [7:0] op, logic [15:0] blk, logic src);
    tws_pkg::item_t it;
    it.action       = act;
    it.byte_count   = bytes;
    it.rx_opcode    = op;
    it.rx_block     = blk;
    it.source_match = src;
    return it;
  endfunction

  // Pick an event that mostly moves the current transfer along.
  function automatic tws_pkg::item_t next_event();
    tws_pkg::item_t it;
    int             roll;
    it = mk_event(tws_pkg::action_t'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 99);
    case (sb.ph)
      tws_pkg::PH_IDLE: begin
        if (roll < 80) it.action = tws_pkg::ACT_START;
      end
      tws_pkg::PH_FETCH: begin
        if (roll < 85) begin
          it.action = tws_pkg::ACT_BLOCK;
          // full blocks keep the transfer going, anything shorter ends it
          if ($urandom_range(0, 3) != 0) it.byte_count = 10'(BLOCK_BYTES);
        end else if (roll < 97) begin
          it.action = ($urandom_range(0, 1) != 0) ? tws_pkg::ACT_PACKET : tws_pkg::ACT_TICK;
        end else begin
          it.action = tws_pkg::ACT_START;
        end
      end
      default: begin
        if (roll < 55) begin
          it = mk_event(tws_pkg::ACT_PACKET, it.byte_count, tws_pkg::OP_ACK, sb.block_num,
                        1'b1);
        end else if (roll < 75) begin
          it.action = tws_pkg::ACT_TICK;
        end else if (roll < 88) begin
          it.action       = tws_pkg::ACT_PACKET;
          it.source_match = 1'b1;
          if (roll < 80) it.rx_opcode = tws_pkg::OP_ACK;
          else if (roll < 84) it.rx_block = sb.block_num;
        end else if (roll < 95) begin
          it.action       = tws_pkg::ACT_PACKET;
          it.source_match = 1'b0;
        end else if (roll < 98) begin
          it.action = tws_pkg::ACT_BLOCK;
        end else begin
          it.action = tws_pkg::ACT_START;
        end
      end
    endcase
    return it;
  endfunction

  task automatic send_event(tws_pkg::item_t it);
    logic [tws_pkg::IN_DATA_W-1:0] word;
    word = '0;
    word[9:0]   = it.byte_count;
    word[17:10] = it.rx_opcode;
    word[33:18] = it.rx_block;
    word[34]    = it.source_match;
    if (idling && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= it.action;
    do @(posedge clk); while (!in_tready);
    sb.note_event(it);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_register(logic [tws_pkg::CFG_IDX_W-1:0] idx,
                                logic [tws_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, value);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic directed_events();
    int i;
    // events outside a transfer are ignored
    send_event(mk_event(tws_pkg::ACT_TICK, 0, 0, 0, 1'b1));
    send_event(mk_event(tws_pkg::ACT_PACKET, 1023, tws_pkg::OP_ACK, 0, 1'b1));
    send_event(mk_event(tws_pkg::ACT_BLOCK, 512, 8'hFF, 16'hFFFF, 1'b1));
    send_event(mk_event(tws_pkg::ACT_START, 0, 0, 0, 1'b0));
    // foreign sender, wrong opcode, wrong block, then the real ACK 0
    send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 0, 1'b0));
    send_event(mk_event(tws_pkg::ACT_PACKET, 0, 8'hFF, 0, 1'b1));
    send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 16'hFFFF, 1'b1));
    send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 0, 1'b1));
    // oversized block saturates to a full one
    send_event(mk_event(tws_pkg::ACT_BLOCK, 1023, 0, 0, 1'b0));
    send_event(mk_event(tws_pkg::ACT_BLOCK, 0, 0, 0, 1'b1));
    send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 0, 1'b1));
    send_event(mk_event(tws_pkg::ACT_PACKET, 0, OP_DATA, 1, 1'b1));
    send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 1, 1'b1));
    send_event(mk_event(tws_pkg::ACT_BLOCK, 512, 0, 0, 1'b0));
    // restart mid-transfer, then run out of ACK 0 attempts
    send_event(mk_event(tws_pkg::ACT_START, 0, 0, 0, 1'b1));
    for (i = 0; i < 3; i++) send_event(mk_event(tws_pkg::ACT_PACKET, 0, 0, 0, 1'b1));
    send_event(mk_event(tws_pkg::ACT_BLOCK, 0, 0, 0, 1'b0));
    send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 1, 1'b1));
    // short block that is never acknowledged: resends, then give up
    send_event(mk_event(tws_pkg::ACT_START, 0, 0, 0, 1'b1));
    send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 0, 1'b1));
    send_event(mk_event(tws_pkg::ACT_BLOCK, 511, 0, 0, 1'b1));
    for (i = 0; i < 5; i++)
      send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 2, 1'b1));
  endtask

  task automatic run_phase(int retries, int timeout, int count, bit exhaust);
    logic [tws_pkg::CFG_DATA_W-1:0] word;
    drain();
    word      = tws_pkg::CFG_DATA_W'($urandom);
    word[7:0] = 8'(retries);
    write_register(tws_pkg::CFG_MAX_RETRIES, word);
    write_register(tws_pkg::CFG_TIMEOUT_TICKS, tws_pkg::CFG_DATA_W'(timeout));
    cfg_valid <= 1'b0;
    settings_used++;
    if (exhaust) begin
      // walk one block through every allowed attempt
      send_event(mk_event(tws_pkg::ACT_START, 0, 0, 0, 1'b1));
      send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 0, 1'b1));
      send_event(mk_event(tws_pkg::ACT_BLOCK, 512, 0, 0, 1'b1));
      repeat (retries)
        send_event(mk_event(tws_pkg::ACT_PACKET, 0, tws_pkg::OP_ACK, 16'hFFFF, 1'b1));
    end
    repeat (count) send_event(next_event());
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_events();
    run_phase(3, 1, 145, 1'b0);
    run_phase(255, 65535, 145, 1'b1);
    run_phase(0, 0, 145, 1'b0);
    run_phase(2, 3, 145, 1'b0);
    run_phase(1, 2, 145, 1'b0);
    run_phase($urandom_range(3, 12), $urandom_range(1, 10), 145, 1'b0);
    run_phase(4, 6, 145, 1'b0);
    idling = 1'b0;
    run_phase(5, 4, 145, 1'b0);
    drain();
    $display("Covered %0d events across %0d register settings plus the reset values.",
             sb.events_seen, settings_used);
    $display("Commands: %0d none, %0d fetch, %0d send, %0d resend, %0d done, %0d fail.",
             sb.cmd_seen[tws_pkg::CMD_NONE], sb.cmd_seen[tws_pkg::CMD_FETCH],
             sb.cmd_seen[tws_pkg::CMD_SEND], sb.cmd_seen[tws_pkg::CMD_RESEND],
             sb.cmd_seen[tws_pkg::CMD_DONE], sb.cmd_seen[tws_pkg::CMD_FAIL]);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
